@@ design/cld_pkg.sv @@
// ----------------------------------------------------------------------------
// cld_pkg
// shared types and constants of the copy/literal delta decoder
// ----------------------------------------------------------------------------
package cld_pkg;

  localparam int BASE_DEPTH = 65536;
  localparam int ADDR_W     = $clog2(BASE_DEPTH);
  localparam int LIMIT_W    = $clog2(BASE_DEPTH + 1);
  localparam int CFG_W      = 17;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [31:0] KIND_BIT = 32'h8000_0000;
  localparam logic [31:0] LEN_MASK = 32'h7fff_ffff;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_DELTA = 2'd1,
    OP_PULL  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_OFFSET  = 2'd1,
    PH_LITERAL = 2'd2,
    PH_COPY    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_RANGE = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        out_from_base;
    logic        copy_pending;
    status_t     status;
    logic        stream_done;
    logic [31:0] produced_count;
  } res_t;

endpackage

@@ design/cld_if.sv @@
// ----------------------------------------------------------------------------
// cld_in_if / cld_out_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface cld_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  data_byte;
  logic [15:0] base_address;
  logic        delta_last;

  modport source(output valid, output operation, output data_byte,
                 output base_address, output delta_last, input ready);
  modport sink(input valid, input operation, input data_byte,
               input base_address, input delta_last, output ready);
endinterface

interface cld_out_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_from_base;
  logic        copy_pending;
  logic [1:0]  status;
  logic        stream_done;
  logic [31:0] produced_count;

  modport source(output valid, output out_valid, output out_byte, output out_from_base,
                 output copy_pending, output status, output stream_done,
                 output produced_count, input ready);
  modport sink(input valid, input out_valid, input out_byte, input out_from_base,
               input copy_pending, input status, input stream_done,
               input produced_count, output ready);
endinterface

@@ design/cld_base_ram.sv @@
// ----------------------------------------------------------------------------
// cld_base_ram
// single-port base byte memory with registered read data
// ----------------------------------------------------------------------------
module cld_base_ram (
  input  logic              clk,
  input  cld_pkg::ram_req_t req,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [cld_pkg::BASE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/cld_parser.sv @@
// ----------------------------------------------------------------------------
// cld_parser
// front end: takes input beats, parses delta records, updates decoder state
// ----------------------------------------------------------------------------
module cld_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [cld_pkg::CFG_W-1:0]   cfg_wr_data,
  cld_in_if.sink                      in_ch,
  input  logic                        space,
  output logic                        push,
  output cld_pkg::res_t               res,
  output cld_pkg::ram_req_t           ram_req
);

  cld_pkg::phase_t                   phase_r, phase_nxt;
  logic [1:0]                        idx_r, idx_nxt;
  logic [23:0]                       hdr_r, hdr_nxt;
  logic [23:0]                       off_r, off_nxt;
  logic [30:0]                       rem_r, rem_nxt;
  logic [cld_pkg::ADDR_W-1:0]        ptr_r, ptr_nxt;
  logic [31:0]                       total_r, total_nxt;
  logic                              last_seen_r, last_seen_nxt;
  logic [cld_pkg::LIMIT_W-1:0]       limit_r, limit_nxt;

  logic        accept;
  logic        busy;
  logic        busy_nxt;
  logic [31:0] full_word;
  logic [32:0] range_end;
  logic [30:0] rem_dec;
  logic [31:0] total_base;
  cld_pkg::op_t op;

  assign in_ch.ready = space;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept;
  assign op          = cld_pkg::op_t'(in_ch.operation);
  assign busy        = (phase_r == cld_pkg::PH_COPY) && (rem_r != 31'd0);

  always_comb begin
    if (32'(cfg_wr_data) > 32'(cld_pkg::BASE_DEPTH)) begin
      limit_nxt = cld_pkg::LIMIT_W'(cld_pkg::BASE_DEPTH);
    end else begin
      limit_nxt = cld_pkg::LIMIT_W'(cfg_wr_data);
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    hdr_nxt       = hdr_r;
    off_nxt       = off_r;
    rem_nxt       = rem_r;
    ptr_nxt       = ptr_r;
    total_nxt     = total_r;
    last_seen_nxt = last_seen_r;
    full_word     = {in_ch.data_byte, 24'd0};
    range_end     = '0;
    rem_dec       = rem_r;
    total_base    = total_r;
    res           = '0;
    res.status    = cld_pkg::ST_OK;
    ram_req       = '0;
    ram_req.addr  = cld_pkg::ADDR_W'(in_ch.base_address);
    ram_req.wdata = in_ch.data_byte;

    if (accept) begin
      unique case (op)
        cld_pkg::OP_LOAD: begin
          ram_req.wr_en = 32'(in_ch.base_address) < 32'(cld_pkg::BASE_DEPTH);
        end
        cld_pkg::OP_DELTA: begin
          if (busy) begin
            res.status = cld_pkg::ST_BUSY;
          end else begin
            if (last_seen_r) begin
              last_seen_nxt = 1'b0;
              total_base    = 32'd0;
            end
            total_nxt = total_base;
            unique case (phase_r)
              cld_pkg::PH_HEADER: begin
                if (idx_r == 2'd3) begin
                  full_word = {in_ch.data_byte, hdr_r};
                  idx_nxt   = 2'd0;
                  rem_nxt   = full_word[30:0];
                  if ((full_word & cld_pkg::KIND_BIT) != 32'd0) begin
                    phase_nxt = (rem_nxt != 31'd0) ? cld_pkg::PH_LITERAL
                                                   : cld_pkg::PH_HEADER;
                  end else begin
                    phase_nxt = cld_pkg::PH_OFFSET;
                  end
                end else begin
                  hdr_nxt[{idx_r, 3'b000} +: 8] = in_ch.data_byte;
                  idx_nxt = idx_r + 2'd1;
                end
              end
              cld_pkg::PH_OFFSET: begin
                if (idx_r == 2'd3) begin
                  full_word = {in_ch.data_byte, off_r};
                  idx_nxt   = 2'd0;
                  range_end = {1'b0, full_word} + 33'(rem_r);
                  if (range_end > 33'(limit_r)) begin
                    res.status = cld_pkg::ST_RANGE;
                    rem_nxt    = 31'd0;
                    phase_nxt  = cld_pkg::PH_HEADER;
                  end else if (rem_r == 31'd0) begin
                    phase_nxt = cld_pkg::PH_HEADER;
                  end else begin
                    ptr_nxt   = cld_pkg::ADDR_W'(full_word);
                    phase_nxt = cld_pkg::PH_COPY;
                  end
                end else begin
                  off_nxt[{idx_r, 3'b000} +: 8] = in_ch.data_byte;
                  idx_nxt = idx_r + 2'd1;
                end
              end
              cld_pkg::PH_LITERAL, cld_pkg::PH_COPY: begin
                res.out_valid = 1'b1;
                res.out_byte  = in_ch.data_byte;
                total_nxt     = total_base + 32'd1;
                if (rem_r != 31'd0) begin
                  rem_dec = rem_r - 31'd1;
                end
                rem_nxt = rem_dec;
                if (rem_dec == 31'd0) begin
                  phase_nxt = cld_pkg::PH_HEADER;
                end
              end
            endcase
            if (in_ch.delta_last) begin
              last_seen_nxt = 1'b1;
              if (phase_nxt == cld_pkg::PH_OFFSET || phase_nxt == cld_pkg::PH_LITERAL ||
                  (phase_nxt == cld_pkg::PH_HEADER && idx_nxt != 2'd0)) begin
                res.status = cld_pkg::ST_TRUNC;
                phase_nxt  = cld_pkg::PH_HEADER;
                idx_nxt    = 2'd0;
                rem_nxt    = 31'd0;
              end
            end
          end
        end
        cld_pkg::OP_PULL: begin
          if (busy) begin
            res.out_valid     = 1'b1;
            res.out_from_base = 1'b1;
            ram_req.rd_en     = 1'b1;
            ram_req.addr      = ptr_r;
            ptr_nxt           = ptr_r + cld_pkg::ADDR_W'(1);
            rem_nxt           = rem_r - 31'd1;
            total_nxt         = total_r + 32'd1;
            if (rem_nxt == 31'd0) begin
              phase_nxt = cld_pkg::PH_HEADER;
            end
          end
        end
        cld_pkg::OP_NONE: begin
        end
      endcase
    end

    busy_nxt           = (phase_nxt == cld_pkg::PH_COPY) && (rem_nxt != 31'd0);
    res.copy_pending   = busy_nxt;
    res.stream_done    = last_seen_nxt && !busy_nxt;
    res.produced_count = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cld_pkg::PH_HEADER;
      idx_r       <= 2'd0;
      rem_r       <= 31'd0;
      ptr_r       <= '0;
      total_r     <= 32'd0;
      last_seen_r <= 1'b0;
      limit_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      rem_r       <= rem_nxt;
      ptr_r       <= ptr_nxt;
      total_r     <= total_nxt;
      last_seen_r <= last_seen_nxt;
      if (cfg_wr_en) begin
        limit_r <= limit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
    off_r <= off_nxt;
  end

  // record phases that emit bytes always hold a nonzero length
  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == cld_pkg::PH_COPY |-> rem_r != 31'd0)
    else $error("copy phase with zero length");

  a_lit_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == cld_pkg::PH_LITERAL |-> rem_r != 31'd0)
    else $error("literal phase with zero length");

  a_idx_phase: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd0 |-> (phase_r == cld_pkg::PH_HEADER || phase_r == cld_pkg::PH_OFFSET))
    else $error("byte index set outside header or offset");

endmodule

@@ design/cld_out_queue.sv @@
// ----------------------------------------------------------------------------
// cld_out_queue
// back end: merges base read data into results and queues them for output
// ----------------------------------------------------------------------------
module cld_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cld_pkg::res_t res,
  input  logic [7:0]    rd_data,
  output logic          space,
  cld_out_if.source     out_ch
);

  logic                        stg_v_r;
  cld_pkg::res_t               stg_r;
  cld_pkg::res_t               stg_res;
  cld_pkg::res_t               fifo_r [cld_pkg::QDEPTH];
  logic [cld_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [cld_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        pop;
  cld_pkg::res_t               head;

  // staging slot plus queue entries bound what may be in flight
  assign space = (cnt_r + cld_pkg::QCNT_W'(stg_v_r)) < cld_pkg::QCNT_W'(cld_pkg::QDEPTH);

  always_comb begin
    stg_res = stg_r;
    if (stg_r.out_from_base) begin
      stg_res.out_byte = rd_data;
    end
  end

  assign head = fifo_r[rd_ptr_r];
  assign pop  = out_ch.valid && out_ch.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (stg_v_r && !pop) begin
      cnt_nxt = cnt_r + cld_pkg::QCNT_W'(1);
    end else if (!stg_v_r && pop) begin
      cnt_nxt = cnt_r - cld_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r  <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      stg_v_r <= push;
      cnt_r   <= cnt_nxt;
      if (stg_v_r) begin
        wr_ptr_r <= wr_ptr_r + cld_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + cld_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stg_r <= res;
    end
    if (stg_v_r) begin
      fifo_r[wr_ptr_r] <= stg_res;
    end
  end

  assign out_ch.valid          = cnt_r != '0;
  assign out_ch.out_valid      = head.out_valid;
  assign out_ch.out_byte       = head.out_byte;
  assign out_ch.out_from_base  = head.out_from_base;
  assign out_ch.copy_pending   = head.copy_pending;
  assign out_ch.status         = head.status;
  assign out_ch.stream_done    = head.stream_done;
  assign out_ch.produced_count = head.produced_count;

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cld_pkg::QCNT_W'(cld_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_stage_room: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r |-> cnt_r < cld_pkg::QCNT_W'(cld_pkg::QDEPTH))
    else $error("staged result with no queue room");

endmodule

@@ design/copy_literal_delta_decoder.sv @@
// ----------------------------------------------------------------------------
// copy_literal_delta_decoder
// rebuilds a byte stream from a base buffer and a copy/literal delta stream
// ----------------------------------------------------------------------------
// Every accepted beat (load, delta byte, pull or no-op) yields exactly one
// result beat, in order. The block takes one beat per clock while in_ch.ready
// is high; the base memory is single ported and sees at most one write (load)
// or one read (pull) per beat. A result passes through the staging slot, where
// the registered base read data is merged in, and then the result queue.
// in_ch.ready drops only while the four-entry result queue and its staging
// slot together hold four results.
// The base memory needs no clearing after reset; only loaded entries may be
// copied. cfg_wr_data sets base_size and may be written only while idle.
module copy_literal_delta_decoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [cld_pkg::CFG_W-1:0] cfg_wr_data,
  cld_in_if.sink                    in_ch,
  cld_out_if.source                 out_ch
);

  logic              space;
  logic              push;
  cld_pkg::res_t     res;
  cld_pkg::ram_req_t ram_req;
  logic [7:0]        rd_data;

  cld_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .space       (space),
    .push        (push),
    .res         (res),
    .ram_req     (ram_req)
  );

  cld_base_ram u_base_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  cld_out_queue u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .res     (res),
    .rd_data (rd_data),
    .space   (space),
    .out_ch  (out_ch)
  );

endmodule
